/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the link transform RTL.
// Included by dh_link_transform_top, which checks its own pipeline control.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, muted during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, muted during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/dhlt_pkg.sv */
// Package for the link transform: sizes, CORDIC constants and helpers.
// Used by every module under hw/rtl.
`default_nettype none
package dhlt_pkg;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int STEPS          = 28;
  localparam int XW             = 34;  // CORDIC X/Y width, 30 fraction bits
  localparam int ZW             = 33;  // residual phase width
  localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam int ROT_W          = 18;
  localparam int LEN_W          = 32;
  localparam int ANG_W          = 16;

  typedef logic signed [XW-1:0] cxy_t;
  typedef logic signed [ZW-1:0] cz_t;

  // Angle steps of the CORDIC in 2^32 counts per turn.
  function automatic cz_t atan_step(input int i);
    case (i)
      0: atan_step = 33'sd536870912;  1: atan_step = 33'sd316933406;
      2: atan_step = 33'sd167458907;  3: atan_step = 33'sd85004756;
      4: atan_step = 33'sd42667331;   5: atan_step = 33'sd21354465;
      6: atan_step = 33'sd10679838;   7: atan_step = 33'sd5340245;
      8: atan_step = 33'sd2670163;    9: atan_step = 33'sd1335087;
      10: atan_step = 33'sd667544;    11: atan_step = 33'sd333772;
      12: atan_step = 33'sd166886;    13: atan_step = 33'sd83443;
      14: atan_step = 33'sd41722;     15: atan_step = 33'sd20861;
      16: atan_step = 33'sd10430;     17: atan_step = 33'sd5215;
      18: atan_step = 33'sd2608;      19: atan_step = 33'sd1304;
      20: atan_step = 33'sd652;       21: atan_step = 33'sd326;
      22: atan_step = 33'sd163;       23: atan_step = 33'sd81;
      24: atan_step = 33'sd41;        25: atan_step = 33'sd20;
      26: atan_step = 33'sd10;        default: atan_step = 33'sd5;
    endcase
  endfunction

  // Payload carried alongside the CORDIC through each cell.
  typedef struct packed {
    logic [1:0]              qt;
    logic [1:0]              qa;
    logic signed [LEN_W-1:0] offs;
    logic signed [LEN_W-1:0] len;
  } side_t;
endpackage
`default_nettype wire

/* hw/rtl/dhlt_cell.sv */
// One CORDIC micro-rotation cell for both angles, with its side payload.
// Depends on dhlt_pkg.
`default_nettype none
module dhlt_cell #(
  parameter int STEP = 0
) (
  input  wire logic           clk,
  input  wire logic           adv,
  input  wire dhlt_pkg::cxy_t  xt_i, yt_i, xa_i, ya_i,
  input  wire dhlt_pkg::cz_t   zt_i, za_i,
  input  wire dhlt_pkg::side_t side_i,
  output dhlt_pkg::cxy_t      xt_o, yt_o, xa_o, ya_o,
  output dhlt_pkg::cz_t       zt_o, za_o,
  output dhlt_pkg::side_t     side_o
);
  import dhlt_pkg::*;
  localparam cz_t ATN = atan_step(STEP);
  cxy_t xt_r, yt_r, xa_r, ya_r;
  cz_t  zt_r, za_r;
  side_t side_r;

  // Rotate both vectors one step toward zero residual.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (!zt_i[ZW-1]) begin
        xt_r <= xt_i - (yt_i >>> STEP); yt_r <= yt_i + (xt_i >>> STEP); zt_r <= zt_i - ATN;
      end else begin
        xt_r <= xt_i + (yt_i >>> STEP); yt_r <= yt_i - (xt_i >>> STEP); zt_r <= zt_i + ATN;
      end
      if (!za_i[ZW-1]) begin
        xa_r <= xa_i - (ya_i >>> STEP); ya_r <= ya_i + (xa_i >>> STEP); za_r <= za_i - ATN;
      end else begin
        xa_r <= xa_i + (ya_i >>> STEP); ya_r <= ya_i - (xa_i >>> STEP); za_r <= za_i + ATN;
      end
      side_r <= side_i;
    end
  end
  assign xt_o = xt_r; assign yt_o = yt_r; assign zt_o = zt_r;
  assign xa_o = xa_r; assign ya_o = ya_r; assign za_o = za_r;
  assign side_o = side_r;
endmodule
`default_nettype wire

/* hw/rtl/dh_link_transform_top.sv */
// Modified DH link transform: row of CORDIC cells, then rounding and products.
// Throughput: one item per cycle; the whole row advances when the output
// register is free or being taken (out_stall low or out_valid low).
// Reset (rst_n low, synchronous) clears every stage valid bit.
// Depends on dhlt_pkg, dhlt_cell and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module dh_link_transform_top #(
  parameter int ANGLE_BITS = dhlt_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = dhlt_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic signed [dhlt_pkg::ANG_W-1:0] in_joint_angle,
  input  wire logic signed [dhlt_pkg::ANG_W-1:0] in_twist_angle,
  input  wire logic signed [dhlt_pkg::LEN_W-1:0] in_link_offset,
  input  wire logic signed [dhlt_pkg::LEN_W-1:0] in_link_length,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic signed [dhlt_pkg::ROT_W-1:0] out_rot_00, out_rot_01, out_rot_10,
  output logic signed [dhlt_pkg::ROT_W-1:0] out_rot_11, out_rot_12, out_rot_20,
  output logic signed [dhlt_pkg::ROT_W-1:0] out_rot_21, out_rot_22,
  output logic signed [dhlt_pkg::LEN_W-1:0] out_pos_x, out_pos_y, out_pos_z
);
  import dhlt_pkg::*;
  localparam int NS  = STEPS + 4;     // cells plus entry, round, product, output
  localparam int SH  = 30 - FRAC_BITS;
  localparam int CW  = FRAC_BITS + 2;  // clamped sin/cos width
  localparam int PW  = 2 * CW;
  localparam int DW  = CW + LEN_W;

  logic adv;
  logic [NS-1:0] vld_r, vld_nxt;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Advance valid bits with the row.
  always_comb begin
    vld_nxt = vld_r;
    if (adv) vld_nxt = {vld_r[NS-2:0], in_valid};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= vld_nxt;
  end
  assign out_valid = vld_r[NS-1];

  // Split one angle into quadrant and residual.
  function automatic logic [ZW+1:0] prep(input logic [ANG_W-1:0] ang);
    logic [31:0] ph, r;
    logic [1:0] q;
    ph = 32'(signed'(ang)) << (32 - ANGLE_BITS);
    q  = 2'((ph + 32'h2000_0000) >> 30);
    r  = ph - {q, 30'd0};
    prep = {q, r[31], r};
  endfunction

  // Entry stage.
  cxy_t xt0_r, xa0_r;
  cz_t  zt0_r, za0_r;
  side_t s0_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      logic [ZW+1:0] pt, pa;
      pt = prep(in_joint_angle);
      pa = prep(in_twist_angle);
      zt0_r <= pt[ZW-1:0]; za0_r <= pa[ZW-1:0];
      xt0_r <= GAIN_Q30; xa0_r <= GAIN_Q30;
      s0_r <= '{qt: pt[ZW+1:ZW], qa: pa[ZW+1:ZW], offs: in_link_offset,
                len: in_link_length};
    end
  end

  cxy_t xt[STEPS+1], yt[STEPS+1], xa[STEPS+1], ya[STEPS+1];
  cz_t  zt[STEPS+1], za[STEPS+1];
  side_t sd[STEPS+1];
  assign xt[0] = xt0_r; assign yt[0] = '0; assign zt[0] = zt0_r;
  assign xa[0] = xa0_r; assign ya[0] = '0; assign za[0] = za0_r;
  assign sd[0] = s0_r;

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    dhlt_cell #(.STEP(g)) u_cell (
      .clk(clk), .adv(adv),
      .xt_i(xt[g]), .yt_i(yt[g]), .xa_i(xa[g]), .ya_i(ya[g]),
      .zt_i(zt[g]), .za_i(za[g]), .side_i(sd[g]),
      .xt_o(xt[g+1]), .yt_o(yt[g+1]), .xa_o(xa[g+1]), .ya_o(ya[g+1]),
      .zt_o(zt[g+1]), .za_o(za[g+1]), .side_o(sd[g+1])
    );
  end

  // Round half up and clamp to plus or minus one.
  function automatic logic signed [CW-1:0] rnd(input cxy_t v);
    cxy_t t;
    t = (v + (cxy_t'(1) <<< (SH - 1))) >>> SH;
    if (t > (cxy_t'(1) <<< FRAC_BITS)) rnd = CW'(1) << FRAC_BITS;
    else if (t < -(cxy_t'(1) <<< FRAC_BITS)) rnd = -(CW'(1) << FRAC_BITS);
    else rnd = t[CW-1:0];
  endfunction

  // Round stage: resolve quadrants.
  logic signed [CW-1:0] ct_r, st_r, ca_r, sa_r;
  side_t s1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [CW-1:0] c, s, c2, s2;
      c = rnd(xt[STEPS]); s = rnd(yt[STEPS]);
      c2 = rnd(xa[STEPS]); s2 = rnd(ya[STEPS]);
      case (sd[STEPS].qt)
        2'd0: begin ct_r <= c;  st_r <= s;  end
        2'd1: begin ct_r <= -s; st_r <= c;  end
        2'd2: begin ct_r <= -c; st_r <= -s; end
        default: begin ct_r <= s; st_r <= -c; end
      endcase
      case (sd[STEPS].qa)
        2'd0: begin ca_r <= c2;  sa_r <= s2;  end
        2'd1: begin ca_r <= -s2; sa_r <= c2;  end
        2'd2: begin ca_r <= -c2; sa_r <= -s2; end
        default: begin ca_r <= s2; sa_r <= -c2; end
      endcase
      s1_r <= sd[STEPS];
    end
  end

  // Product stage: raw products, registered.
  logic signed [PW-1:0] p10_r, p11_r, p20_r, p21_r;
  logic signed [DW-1:0] py_r, pz_r;
  logic signed [CW-1:0] ct2_r, st2_r, ca2_r, sa2_r;
  logic signed [LEN_W-1:0] len2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p10_r <= PW'(st_r) * PW'(ca_r); p11_r <= PW'(ct_r) * PW'(ca_r);
      p20_r <= PW'(st_r) * PW'(sa_r); p21_r <= PW'(ct_r) * PW'(sa_r);
      py_r  <= DW'(sa_r) * DW'(s1_r.offs); pz_r <= DW'(ca_r) * DW'(s1_r.offs);
      ct2_r <= ct_r; st2_r <= st_r; ca2_r <= ca_r; sa2_r <= sa_r;
      len2_r <= s1_r.len;
    end
  end

  function automatic logic signed [PW-1:0] rp(input logic signed [PW-1:0] p);
    rp = (p + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [LEN_W-1:0] sat(input logic signed [DW:0] v);
    if (v > (DW+1)'(33'sh0_7FFF_FFFF)) sat = 32'sh7FFF_FFFF;
    else if (v < -(DW+1)'(33'sh0_8000_0000)) sat = 32'sh8000_0000;
    else sat = v[LEN_W-1:0];
  endfunction

  // Output register: round products, saturate the y and z translations.
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [DW:0] ry, rz;
      ry = ((DW+1)'(py_r) + ((DW+1)'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      rz = ((DW+1)'(pz_r) + ((DW+1)'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      out_rot_00 <= ROT_W'(ct2_r);
      out_rot_01 <= ROT_W'(-(CW+1)'(st2_r));
      out_rot_10 <= ROT_W'(rp(p10_r));
      out_rot_11 <= ROT_W'(rp(p11_r));
      out_rot_12 <= ROT_W'(-(CW+1)'(sa2_r));
      out_rot_20 <= ROT_W'(rp(p20_r));
      out_rot_21 <= ROT_W'(rp(p21_r));
      out_rot_22 <= ROT_W'(ca2_r);
      out_pos_x  <= len2_r;
      out_pos_y  <= sat(-ry);
      out_pos_z  <= sat(rz);
    end
  end

  `ASSERT_IMPL(a_stall_hold, clk, rst_n, out_valid && out_stall, in_stall)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_fill, clk, rst_n, in_valid && !in_stall, vld_r[0])
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Testbench for dh_link_transform_top: directed table, then random link parameters.
// Predicts each transform with a local CORDIC model; depends on dhlt_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import dhlt_pkg::*;

  typedef struct packed {
    logic signed [ANG_W-1:0] theta;
    logic signed [ANG_W-1:0] alpha;
    logic signed [LEN_W-1:0] offs;
    logic signed [LEN_W-1:0] len;
  } link_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] r00, r01, r10, r11, r12, r20, r21, r22;
    logic signed [LEN_W-1:0] px, py, pz;
  } frame_t;

  localparam int FB = FRAC_BITS_DEF;
  localparam logic signed [ROT_W-1:0] ONE = 18'sd65536;
  localparam logic signed [ROT_W-1:0] NEG_ONE = -18'sd65536;
  localparam logic signed [ROT_W-1:0] ZERO = 18'sd0;
  localparam logic signed [LEN_W-1:0] LMAX = 32'sh7fffffff;
  localparam logic signed [LEN_W-1:0] LMIN = 32'sh80000000;
  localparam int N_RANDOM = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  link_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  frame_t out_item;

  logic signed [ROT_W-1:0] r00, r01, r10, r11, r12, r20, r21, r22;
  logic signed [LEN_W-1:0] px, py, pz;

  frame_t expected_frames[$];
  int errors = 0;
  bit drive_done = 1'b0;
  bit hold_stalls = 1'b0;

  dh_link_transform_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_joint_angle(in_item.theta), .in_twist_angle(in_item.alpha),
    .in_link_offset(in_item.offs), .in_link_length(in_item.len),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_rot_00(r00), .out_rot_01(r01), .out_rot_10(r10), .out_rot_11(r11),
    .out_rot_12(r12), .out_rot_20(r20), .out_rot_21(r21), .out_rot_22(r22),
    .out_pos_x(px), .out_pos_y(py), .out_pos_z(pz)
  );

  assign out_item = '{r00, r01, r10, r11, r12, r20, r21, r22, px, py, pz};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Arithmetic shift right with floor, for the wide signed values below.
  function automatic longint fshift(input longint v, input int s);
    fshift = v >>> s;
  endfunction

  function automatic longint clamp_one(input longint v);
    longint one;
    one = longint'(1) << FB;
    clamp_one = (v > one) ? one : ((v < -one) ? -one : v);
  endfunction

  // Cosine and sine of a binary angle, Q1.16, quadrant plus CORDIC residual.
  task automatic cos_sin(input logic signed [ANG_W-1:0] ang,
                         output longint c_o, output longint s_o);
    logic [31:0] phase, r;
    logic [1:0] q;
    longint x, y, z, dx, dy, c, s, half;
    phase = {ang, 16'h0};
    q = 2'((phase + 32'h20000000) >> 30);
    r = phase - ({30'b0, q} << 30);
    z = r[31] ? longint'(r) - (longint'(1) << 32) : longint'(r);
    x = 652032874;
    y = 0;
    half = longint'(1) << (29 - FB);
    for (int i = 0; i < STEPS; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_step(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_step(i));
      end
    end
    c = clamp_one(fshift(x + half, 30 - FB));
    s = clamp_one(fshift(y + half, 30 - FB));
    case (q)
      2'd0: begin c_o = c; s_o = s; end
      2'd1: begin c_o = -s; s_o = c; end
      2'd2: begin c_o = -c; s_o = -s; end
      default: begin c_o = s; s_o = -c; end
    endcase
  endtask

  function automatic longint fx_mul(input longint a, input longint b);
    fx_mul = fshift(a * b + (longint'(1) << (FB - 1)), FB);
  endfunction

  function automatic logic signed [LEN_W-1:0] sat_len(input longint v);
    sat_len = (v > 64'sd2147483647) ? LMAX : ((v < -64'sd2147483648) ? LMIN : v[31:0]);
  endfunction

  task automatic link_frame(input link_t it, output frame_t f);
    longint ct, st, ca, sa;
    cos_sin(it.theta, ct, st);
    cos_sin(it.alpha, ca, sa);
    f.r00 = ct[17:0];
    f.r01 = 18'(-st);
    f.r10 = 18'(fx_mul(st, ca));
    f.r11 = 18'(fx_mul(ct, ca));
    f.r12 = 18'(-sa);
    f.r20 = 18'(fx_mul(st, sa));
    f.r21 = 18'(fx_mul(ct, sa));
    f.r22 = ca[17:0];
    f.px = it.len;
    f.py = sat_len(-fx_mul(sa, longint'(it.offs)));
    f.pz = sat_len(fx_mul(ca, longint'(it.offs)));
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    gap_len = (p < 55) ? 0 : ((p < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60));
  endfunction

  // Send one item at the falling edge, hold it until accepted.
  task automatic send_link(input link_t it);
    frame_t f;
    link_frame(it, f);
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_frames.push_back(f);
    @(negedge clk);
  endtask

  // Drop valid for the given gap; a zero-length gap leaves valid alone.
  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic link_t rand_link(input int k);
    link_t it;
    it.theta = ANG_W'($urandom);
    it.alpha = ANG_W'($urandom);
    it.offs = $urandom;
    it.len = $urandom;
    // mostly moderate offsets so products stay in range, some full-scale
    if (k % 4 != 0) it.offs = 32'(signed'(it.offs) >>> $urandom_range(0, 16));
    if (k % 7 == 0) it.theta = 16'(({$urandom_range(0, 7)} * 8192) + $urandom_range(0, 2) - 1);
    return it;
  endfunction

  // Directed rows: angles at quadrant edges, length extremes; expected typed in
  // where read off directly, else predicted.
  typedef struct {
    link_t it;
    bit typed;
    frame_t f;
  } row_t;

  row_t dir_rows[$];

  task automatic add_row(input link_t it, input bit typed, input frame_t f);
    row_t rw;
    rw.it = it; rw.typed = typed; rw.f = f;
    dir_rows.push_back(rw);
  endtask

  // Stimulus.
  initial begin
    frame_t f;
    link_t it;
    add_row('{16'sd0, 16'sd0, 32'sd0, 32'sd0}, 1,
            '{ONE, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE, 32'sd0, 32'sd0, 32'sd0});
    add_row('{16'sd0, 16'sd0, LMAX, LMIN}, 1,
            '{ONE, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE, LMIN, 32'sd0, LMAX});
    add_row('{16'sd0, 16'sd16384, LMIN, LMAX}, 1,
            '{ONE, ZERO, ZERO, ZERO, NEG_ONE, ZERO, ONE, ZERO, LMAX, LMAX, 32'sd0});
    add_row('{-16'sd32768, -16'sd32768, LMIN, 32'sd65536}, 1,
            '{NEG_ONE, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, NEG_ONE, 32'sd65536,
              32'sd0, LMAX});
    add_row('{16'sd16384, -16'sd16384, 32'sd65536, -32'sd1}, 1,
            '{ZERO, NEG_ONE, ZERO, ZERO, ONE, NEG_ONE, ZERO, ZERO, -32'sd1,
              32'sd65536, 32'sd0});
    foreach (dir_rows[i]) ;
    for (int k = 0; k < 16; k++) begin
      it.theta = 16'(k * 4096 + ((k & 1) ? 1 : -1));
      it.alpha = 16'sh7fff ^ 16'(k * 5461);
      it.offs = (k & 2) ? LMAX : -32'sd98304;
      it.len = (k & 4) ? 32'sh5555aaaa : 32'shaaaa5555;
      add_row(it, 0, f);
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (dir_rows[i]) begin
      send_link(dir_rows[i].it);
      if (dir_rows[i].typed) expected_frames[$] = dir_rows[i].f;
      if (i % 3 == 0) idle_gap(gap_len());
    end
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == 400) begin
        // drain the pipeline completely before going on
        in_valid <= 1'b0;
        wait (expected_frames.size() == 0);
        @(negedge clk);
      end
      hold_stalls = (k >= 600 && k < 700);
      send_link(rand_link(k));
      if (k < 600 || k >= 700) idle_gap(gap_len());
    end
    in_valid <= 1'b0;
    drive_done = 1'b1;
  end

  // Result side stall.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      n = hold_stalls ? 0 : gap_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Check each accepted result against the oldest prediction.
  always @(posedge clk) begin
    frame_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_item);
      end else begin
        e = expected_frames.pop_front();
        if (e !== out_item) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp %h %h %h %h %h %h %h %h %h %h %h",
                     e.r00, e.r01, e.r10, e.r11, e.r12, e.r20, e.r21, e.r22,
                     e.px, e.py, e.pz);
            $display("     got %h %h %h %h %h %h %h %h %h %h %h",
                     r00, r01, r10, r11, r12, r20, r21, r22, px, py, pz);
          end
        end
      end
    end
  end

  // Finish after draining plus pipeline latency.
  initial begin
    wait (drive_done);
    wait (expected_frames.size() == 0);
    repeat (80) @(posedge clk);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
